[design/smmk_pkg.sv]
// Shared types, widths and codes for the sensor min/max-k tracker.
// No dependencies; imported by every module of the block.
`default_nettype none

package smmk_pkg;

   localparam int CHANNELS_DEF = 8;
   localparam int KEEP_DEF     = 8;

   localparam int MODE_W   = 2;
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 12;
   localparam int LOW_W    = 14;
   localparam int HIGH_W   = 12;

   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPORT = 2'd2;

   localparam logic [LOW_W-1:0]  LOW_INIT  = 14'h3FFF;
   localparam logic [HIGH_W-1:0] HIGH_INIT = 12'h000;

   typedef struct packed {
      logic write;
      logic clear;
   } cell_ctl_type;

endpackage

`default_nettype wire

[design/smmk_cell.sv]
// One position of the sorted low and high sets, held for every channel.
// Uses smmk_pkg; instanced KEEP times in a row by the top level.
`default_nettype none

module smmk_cell #(
   parameter int CHANNELS = smmk_pkg::CHANNELS_DEF,
   parameter int CH_W     = 3
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire smmk_pkg::cell_ctl_type      ctl,
   input  wire logic [CH_W-1:0]             index,
   input  wire logic [smmk_pkg::SAMPLE_W-1:0] value,
   input  wire logic [smmk_pkg::LOW_W-1:0]  left_low,
   input  wire logic [smmk_pkg::HIGH_W-1:0] left_high,
   output logic      [smmk_pkg::LOW_W-1:0]  low_out,
   output logic      [smmk_pkg::HIGH_W-1:0] high_out
);
   import smmk_pkg::*;

   logic [LOW_W-1:0]  low_ff  [CHANNELS];
   logic [HIGH_W-1:0] high_ff [CHANNELS];
   logic [LOW_W-1:0]  low_in;
   logic [HIGH_W-1:0] high_in;
   logic [LOW_W-1:0]  v_low;

   assign low_out  = low_ff[index];
   assign high_out = high_ff[index];
   assign v_low    = LOW_W'(value);

   // keep own entry, take the new word, or take the neighbour's entry
   always_comb begin
      if (low_out <= v_low) begin
         low_in = low_out;
      end else if (left_low <= v_low) begin
         low_in = v_low;
      end else begin
         low_in = left_low;
      end
      if (high_out >= value) begin
         high_in = high_out;
      end else if (left_high >= value) begin
         high_in = value;
      end else begin
         high_in = left_high;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            low_ff[c]  <= LOW_INIT;
            high_ff[c] <= HIGH_INIT;
         end
      end else if (ctl.write) begin
         low_ff[index]  <= low_in;
         high_ff[index] <= high_in;
      end
   end

endmodule

`default_nettype wire

[design/smmk_avg.sv]
// Truncated mean of a set sum: sum / KEEP by reciprocal multiplication.
// Uses smmk_pkg defaults; result is registered by the top level.
`default_nettype none

module smmk_avg #(
   parameter int KEEP  = smmk_pkg::KEEP_DEF,
   parameter int IN_W  = 17,
   parameter int OUT_W = 14
) (
   input  wire logic [IN_W-1:0]  sum,
   output logic      [OUT_W-1:0] avg
);
   import smmk_pkg::*;

   localparam int     L      = $clog2(KEEP);
   localparam int     SHIFT  = IN_W + L;
   localparam int     PROD_W = 2 * IN_W + 1;
   localparam longint MUL    = ((longint'(1) <<< SHIFT) + longint'(KEEP) - 1) / longint'(KEEP);
   localparam logic [IN_W:0] MUL_C = (IN_W + 1)'(MUL);

   logic [PROD_W-1:0] prod;

   assign prod = PROD_W'(sum) * PROD_W'(MUL_C);
   assign avg  = prod[SHIFT +: OUT_W];

endmodule

`default_nettype wire

[design/sensor_min_max_k_tracker.sv]
// Top level of the sensor min/max-k tracker: cell row, running sums, report path.
// Uses smmk_pkg, smmk_cell and smmk_avg.
//
//   channel | direction | tdata (low bit up)              | tuser
//   req_    | in        | channel[3], sample[12], pad     | mode[2]
//   rsp_    | out       | out_channel[3], lower_average[14],
//           |           | upper_average[12], pad          | -
//
// Samples and clears apply on acceptance; a word can follow every cycle unless stalled.
// A report reads the channel's running sums into registers, then a reciprocal multiply
// stage forms both means, registered when the result word is empty or being taken.
// req_tready drops only while a report waits behind an unaccepted result.
// Synchronous reset loads every set and sum at once; no clearing pass.
`default_nettype none

module sensor_min_max_k_tracker #(
   parameter int CHANNELS = smmk_pkg::CHANNELS_DEF,
   parameter int KEEP     = smmk_pkg::KEEP_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [smmk_pkg::REQ_DATA_W-1:0] req_tdata,  // channel, sample, pad
   input  wire logic [smmk_pkg::MODE_W-1:0]     req_tuser,  // mode
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic      [smmk_pkg::RSP_DATA_W-1:0] rsp_tdata   // out_channel, lower, upper, pad
);
   import smmk_pkg::*;

   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int L      = $clog2(KEEP);
   localparam int LSUM_W = LOW_W + L;
   localparam int HSUM_W = HIGH_W + L;
   localparam logic [LSUM_W-1:0] LSUM_INIT = LSUM_W'(KEEP * int'(LOW_INIT));
   localparam logic [HSUM_W-1:0] HSUM_INIT = HSUM_W'(KEEP * int'(HIGH_INIT));

   logic [MODE_W-1:0]   mode;
   logic [CHAN_W-1:0]   chan;
   logic [SAMPLE_W-1:0] sample;
   logic [4:0]          chan_ext;
   logic [CH_W-1:0]     idx;
   logic                accept;
   logic                chan_ok;
   logic                report;
   cell_ctl_type        ctl;

   logic [LOW_W-1:0]    low_rd  [KEEP];
   logic [HIGH_W-1:0]   high_rd [KEEP];
   logic [LOW_W-1:0]    v_low;
   logic                low_enter;
   logic                high_enter;

   logic [LSUM_W-1:0]   lsum_ff [CHANNELS];
   logic [HSUM_W-1:0]   hsum_ff [CHANNELS];
   logic [LSUM_W-1:0]   lsum_in;
   logic [HSUM_W-1:0]   hsum_in;

   logic                s1_valid_ff;
   logic [CHAN_W-1:0]   s1_chan_ff;
   logic [LSUM_W-1:0]   s1_lsum_ff;
   logic [HSUM_W-1:0]   s1_hsum_ff;
   logic                advance;

   logic [LOW_W-1:0]    low_avg;
   logic [HIGH_W-1:0]   high_avg;
   logic                rsp_valid_ff;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [LOW_W-1:0]    rsp_low_ff;
   logic [HIGH_W-1:0]   rsp_high_ff;

   assign mode     = req_tuser;
   assign chan     = req_tdata[CHAN_W-1:0];
   assign sample   = req_tdata[CHAN_W +: SAMPLE_W];
   assign chan_ext = 5'(chan);
   assign idx      = chan_ext[CH_W-1:0];
   assign chan_ok  = chan_ext < 5'(CHANNELS);

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign ctl.write = accept && mode == MODE_SAMPLE && chan_ok;
   assign ctl.clear = accept && mode == MODE_CLEAR;
   assign report    = accept && mode == MODE_REPORT && chan_ok;

   for (genvar p = 0; p < KEEP; p++) begin : g_cell
      logic [LOW_W-1:0]  left_low;
      logic [HIGH_W-1:0] left_high;
      if (p == 0) begin : g_head
         // head cell: the new word always fits left of it
         assign left_low  = '0;
         assign left_high = '1;
      end else begin : g_body
         assign left_low  = low_rd[p-1];
         assign left_high = high_rd[p-1];
      end
      smmk_cell #(
         .CHANNELS (CHANNELS),
         .CH_W     (CH_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctl       (ctl),
         .index     (idx),
         .value     (sample),
         .left_low  (left_low),
         .left_high (left_high),
         .low_out   (low_rd[p]),
         .high_out  (high_rd[p])
      );
   end

   // running sums follow the word that enters and the tail entry that drops out
   assign v_low      = LOW_W'(sample);
   assign low_enter  = v_low < low_rd[KEEP-1];
   assign high_enter = sample > high_rd[KEEP-1];

   always_comb begin
      lsum_in = lsum_ff[idx];
      hsum_in = hsum_ff[idx];
      if (low_enter) begin
         lsum_in = lsum_ff[idx] + LSUM_W'(v_low) - LSUM_W'(low_rd[KEEP-1]);
      end
      if (high_enter) begin
         hsum_in = hsum_ff[idx] + HSUM_W'(sample) - HSUM_W'(high_rd[KEEP-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clear) begin
         for (int c = 0; c < CHANNELS; c++) begin
            lsum_ff[c] <= LSUM_INIT;
            hsum_ff[c] <= HSUM_INIT;
         end
      end else if (ctl.write) begin
         lsum_ff[idx] <= lsum_in;
         hsum_ff[idx] <= hsum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (report) begin
         s1_valid_ff <= 1'b1;
      end else if (advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (report) begin
         s1_chan_ff <= chan;
         s1_lsum_ff <= lsum_ff[idx];
         s1_hsum_ff <= hsum_ff[idx];
      end
   end

   smmk_avg #(
      .KEEP  (KEEP),
      .IN_W  (LSUM_W),
      .OUT_W (LOW_W)
   ) u_low_avg (
      .sum (s1_lsum_ff),
      .avg (low_avg)
   );

   smmk_avg #(
      .KEEP  (KEEP),
      .IN_W  (HSUM_W),
      .OUT_W (HIGH_W)
   ) u_high_avg (
      .sum (s1_hsum_ff),
      .avg (high_avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_chan_ff <= s1_chan_ff;
         rsp_low_ff  <= low_avg;
         rsp_high_ff <= high_avg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_high_ff, rsp_low_ff, rsp_chan_ff});

endmodule

`default_nettype wire

[design/smmk_checker.sv]
// Port-level checks for the sensor min/max-k tracker, bound to the top level.
// Uses smmk_pkg.
`default_nettype none

module smmk_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic [smmk_pkg::MODE_W-1:0]     req_tuser,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [smmk_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import smmk_pkg::*;

   logic req_acc;
   assign req_acc = req_tvalid && req_tready;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without a waiting result");

   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_acc && req_tuser == MODE_REPORT, 2))
      else $error("result word without a report two cycles earlier");

   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:CHAN_W+LOW_W+HIGH_W] == '0)
      else $error("result padding not zero");

endmodule

bind sensor_min_max_k_tracker smmk_checker u_smmk_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/sensor_min_max_k_tracker_checker.sv]
// Checker for the sensor min/max-k tracker: watches both stream channels,
// keeps its own per-channel sorted sets and compares every report word.
// Depends on smmk_pkg.
module sensor_min_max_k_tracker_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [smmk_pkg::REQ_DATA_W-1:0] req_tdata,  // channel, sample, pad
   input  wire logic [smmk_pkg::MODE_W-1:0]     req_tuser,  // mode
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [smmk_pkg::RSP_DATA_W-1:0] rsp_tdata,  // out_channel, lower, upper, pad
   output int                                   fail_count,
   output int                                   reports_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import smmk_pkg::*;

   localparam int CHANNELS = CHANNELS_DEF;
   localparam int KEEP     = KEEP_DEF;

   typedef struct packed {
      logic [CHAN_W-1:0] chan;
      logic [LOW_W-1:0]  lower;
      logic [HIGH_W-1:0] upper;
   } report_type;

   report_type        report_q[$];
   logic [LOW_W-1:0]  low_keep  [CHANNELS][KEEP];
   logic [HIGH_W-1:0] high_keep [CHANNELS][KEEP];
   int                fails = 0;

   function automatic void reload_sets();
      for (int c = 0; c < CHANNELS; c++) begin
         for (int k = 0; k < KEEP; k++) begin
            low_keep[c][k]  = LOW_INIT;
            high_keep[c][k] = HIGH_INIT;
         end
      end
   endfunction

   // sorted insert: entry KEEP-1 is the worst of each set, ties with it never enter
   function automatic void keep_sample(int ch, logic [SAMPLE_W-1:0] value);
      int               p;
      logic [LOW_W-1:0] lv;
      lv = LOW_W'(value);
      if (lv < low_keep[ch][KEEP-1]) begin
         p = KEEP - 1;
         while (p > 0 && low_keep[ch][p-1] > lv) begin
            low_keep[ch][p] = low_keep[ch][p-1];
            p--;
         end
         low_keep[ch][p] = lv;
      end
      if (value > high_keep[ch][KEEP-1]) begin
         p = KEEP - 1;
         while (p > 0 && high_keep[ch][p-1] < value) begin
            high_keep[ch][p] = high_keep[ch][p-1];
            p--;
         end
         high_keep[ch][p] = value;
      end
   endfunction

   function automatic report_type averages_of(int ch);
      int unsigned lsum;
      int unsigned hsum;
      report_type  r;
      lsum = 0;
      hsum = 0;
      for (int k = 0; k < KEEP; k++) begin
         lsum += low_keep[ch][k];
         hsum += high_keep[ch][k];
      end
      r.chan  = CHAN_W'(ch);
      r.lower = LOW_W'(lsum / KEEP);
      r.upper = HIGH_W'(hsum / KEEP);
      return r;
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, want, got);
         fails++;
      end
   endfunction

   always @(posedge clock) begin
      report_type got;
      report_type want;
      int         ch;
      if (reset) begin
         reload_sets();
         report_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            ch = int'(req_tdata[CHAN_W-1:0]);
            case (req_tuser)
               MODE_SAMPLE: if (ch < CHANNELS) keep_sample(ch, req_tdata[CHAN_W +: SAMPLE_W]);
               MODE_CLEAR:  reload_sets();
               MODE_REPORT: if (ch < CHANNELS) report_q.push_back(averages_of(ch));
               default:     ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.chan  = rsp_tdata[CHAN_W-1:0];
            got.lower = rsp_tdata[CHAN_W +: LOW_W];
            got.upper = rsp_tdata[CHAN_W+LOW_W +: HIGH_W];
            if (report_q.size() == 0) begin
               $display("%0t: unexpected report word, expected none actual %h",
                        $realtime, rsp_tdata);
               fails++;
            end else begin
               want = report_q.pop_front();
               check_field("out_channel", want.chan, got.chan);
               check_field("lower_average", want.lower, got.lower);
               check_field("upper_average", want.upper, got.upper);
            end
         end
      end
      reports_due <= report_q.size();
      fail_count  <= fails;
   end

endmodule

[tb/sensor_min_max_k_tracker_tb.sv]
// Top of the sensor min/max-k tracker testbench: clock, reset, stimulus and verdict.
// Depends on smmk_pkg, sensor_min_max_k_tracker and sensor_min_max_k_tracker_checker.
module sensor_min_max_k_tracker_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smmk_pkg::*;

   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
   localparam int                PHASE_WORDS = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [MODE_W-1:0]     req_tuser  = MODE_SAMPLE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   int                    fail_count;
   int                    reports_due;
   int                    send_idle = 8;
   int                    recv_idle = 65;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   sensor_min_max_k_tracker DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   sensor_min_max_k_tracker_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .fail_count  (fail_count),
      .reports_due (reports_due)
   );

   always @(posedge clock) begin
      rsp_tready <= !reset && ($urandom_range(0, 99) >= recv_idle);
   end

   task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CHAN_W-1:0] chan,
                            input logic [SAMPLE_W-1:0] value);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'({value, chan});
      do @(posedge clock); while (!req_tready);
   endtask

   // narrow bands make ties with the worst entry common
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 3))
         0:       return SAMPLE_W'($urandom_range(0, 4095));
         1:       return SAMPLE_W'($urandom_range(0, 31));
         2:       return SAMPLE_W'($urandom_range(4064, 4095));
         default: return SAMPLE_W'(12'h800 + $urandom_range(0, 3));
      endcase
   endfunction

   initial begin
      int                words;
      int                r;
      logic [CHAN_W-1:0] chan;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset values on every channel, extremes, a tie, an ignored mode, a clear
      for (int c = 0; c < 8; c++) send_word(MODE_REPORT, CHAN_W'(c), '0);
      send_word(MODE_SAMPLE, 3'd0, 12'hFFF);
      send_word(MODE_SAMPLE, 3'd0, 12'h000);
      send_word(MODE_SAMPLE, 3'd0, 12'h000);
      send_word(MODE_REPORT, 3'd0, 12'hFFF);
      send_word(MODE_UNUSED, 3'd2, 12'hFFF);
      send_word(MODE_REPORT, 3'd2, '0);
      send_word(MODE_CLEAR, 3'd5, 12'hABC);
      send_word(MODE_REPORT, 3'd0, '0);
      send_word(MODE_SAMPLE, 3'd7, 12'h555);
      send_word(MODE_SAMPLE, 3'd7, 12'hAAA);
      send_word(MODE_REPORT, 3'd7, '0);

      for (int phase = 0; phase < 3; phase++) begin
         send_idle = (phase == 0) ? 8 : (phase == 1) ? 65 : 0;
         recv_idle = (phase == 0) ? 65 : (phase == 1) ? 8 : 0;
         words = 0;
         while (words < PHASE_WORDS) begin
            r    = $urandom_range(0, 99);
            chan = ($urandom_range(0, 3) == 0) ? CHAN_W'($urandom_range(0, 1))
                                               : CHAN_W'($urandom_range(0, 7));
            if (r < 80) begin
               send_word(MODE_SAMPLE, chan, pick_sample());
               words++;
            end else if (r < 96) begin
               send_word(MODE_REPORT, chan, SAMPLE_W'($urandom_range(0, 4095)));
               words++;
            end else if (r < 97) begin
               send_word(MODE_CLEAR, chan, SAMPLE_W'($urandom_range(0, 4095)));
               words++;
            end else begin
               send_word(MODE_UNUSED, chan, SAMPLE_W'($urandom_range(0, 4095)));
            end
         end
      end
      req_tvalid <= 1'b0;

      do @(posedge clock); while (reports_due != 0);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("sensor_min_max_k_tracker_tb: PASS");
      end else begin
         $display("sensor_min_max_k_tracker_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("sensor_min_max_k_tracker_tb: FAIL");
      $finish;
   end

endmodule

[files.f]
design/smmk_pkg.sv
design/smmk_cell.sv
design/smmk_avg.sv
design/sensor_min_max_k_tracker.sv
design/smmk_checker.sv
tb/sensor_min_max_k_tracker_checker.sv
tb/sensor_min_max_k_tracker_tb.sv
